FILE: src/tlc_pkg.sv
// Package for the traffic light controller.
// Holds the beat and configuration types, register indexes and reset values.
// No dependencies.
package tlc_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] CFG_GREEN_TICKS   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_YELLOW_TICKS  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RED_TICKS     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_BLINK_TICKS   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_PRE_RED_TICKS = 3'd4;

  localparam logic [CfgWidth-1:0] GreenTicksReset  = 16'd700;
  localparam logic [CfgWidth-1:0] YellowTicksReset = 16'd800;
  localparam logic [CfgWidth-1:0] RedTicksReset    = 16'd1000;
  localparam logic [CfgWidth-1:0] BlinkTicksReset  = 16'd50;
  localparam logic [CfgWidth-1:0] PreRedTicksReset = 16'd200;

  typedef struct packed {
    logic mode_button;
    logic red_button;
    logic yellow_button;
    logic green_button;
  } in_t;

  typedef struct packed {
    logic red_lamp;
    logic yellow_lamp;
    logic green_lamp;
    logic in_manual;
  } out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] green_ticks;
    logic [CfgWidth-1:0] yellow_ticks;
    logic [CfgWidth-1:0] red_ticks;
    logic [CfgWidth-1:0] blink_ticks;
    logic [CfgWidth-1:0] pre_red_ticks;
  } cfg_t;

endpackage

FILE: src/tlc_core.sv
// Phase state and lamp logic of the traffic light controller, one tick per step.
// Depends on tlc_pkg for the beat and configuration types.
module tlc_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  tlc_pkg::in_t  tick_i,
  input  tlc_pkg::cfg_t cfg_i,
  output tlc_pkg::out_t res_o
);

  localparam int unsigned CmpWidth =
      (COUNT_WIDTH > tlc_pkg::CfgWidth) ? COUNT_WIDTH : tlc_pkg::CfgWidth;

  localparam logic [1:0] AP_GREEN  = 2'd0;
  localparam logic [1:0] AP_YELLOW = 2'd1;
  localparam logic [1:0] AP_RED    = 2'd2;

  localparam logic [2:0] MP_OFF     = 3'd0;
  localparam logic [2:0] MP_RED     = 3'd1;
  localparam logic [2:0] MP_YELLOW  = 3'd2;
  localparam logic [2:0] MP_BLINK   = 3'd3;
  localparam logic [2:0] MP_PRE_RED = 3'd4;
  localparam logic [2:0] MP_GREEN   = 3'd5;

  localparam int unsigned LampRed = 0;
  localparam int unsigned LampYel = 1;
  localparam int unsigned LampGrn = 2;

  logic                   manual_q, manual_d;
  logic [3:0]             prev_q, prev_d;
  logic [1:0]             aphase_q, aphase_d;
  logic [2:0]             mphase_q, mphase_d;
  logic [COUNT_WIDTH-1:0] phase_cnt_q, phase_cnt_d;
  logic [COUNT_WIDTH-1:0] ablink_cnt_q, ablink_cnt_d;
  logic [COUNT_WIDTH-1:0] mblink_cnt_q, mblink_cnt_d;
  logic [COUNT_WIDTH-1:0] prered_cnt_q, prered_cnt_d;
  logic [1:0]             blink_q, blink_d;
  logic [2:0]             lamps_q, lamps_d;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic expired(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [tlc_pkg::CfgWidth-1:0] lim);
    expired = CmpWidth'(cnt) >= CmpWidth'(lim);
  endfunction

  always_comb begin
    logic [3:0]             buttons;
    logic [3:0]             edges;
    logic [COUNT_WIDTH-1:0] pc, abc, mbc, prc;

    buttons = {tick_i.green_button, tick_i.yellow_button, tick_i.red_button,
               tick_i.mode_button};
    edges = buttons & ~prev_q;
    manual_d = manual_q;
    prev_d = {prev_q[3:1], buttons[0]};
    aphase_d = aphase_q;
    mphase_d = mphase_q;
    blink_d = blink_q;
    lamps_d = lamps_q;
    pc = phase_cnt_q;
    abc = ablink_cnt_q;
    mbc = mblink_cnt_q;
    prc = prered_cnt_q;

    if (edges[0]) begin
      manual_d = ~manual_q;
      lamps_d = '0;
      if (!manual_q) begin
        mphase_d = MP_OFF;
      end else begin
        aphase_d = AP_GREEN;
        pc = '0;
      end
    end

    if (manual_d) begin
      if (edges[1]) begin
        if (mphase_d == MP_RED) begin
          mphase_d = MP_OFF;
        end else begin
          mphase_d = MP_PRE_RED;
          mbc = '0;
          prc = '0;
          blink_d[1] = 1'b1;
        end
      end
      if (edges[2]) begin
        if (mphase_d == MP_YELLOW || mphase_d == MP_BLINK) begin
          mphase_d = MP_OFF;
        end else begin
          mphase_d = MP_BLINK;
          mbc = '0;
          blink_d[1] = 1'b1;
        end
      end
      if (edges[3]) begin
        mphase_d = (mphase_d == MP_GREEN) ? MP_OFF : MP_GREEN;
      end
      unique case (mphase_d)
        MP_RED:    lamps_d = 3'b001;
        MP_YELLOW: lamps_d = 3'b010;
        MP_GREEN:  lamps_d = 3'b100;
        MP_BLINK, MP_PRE_RED: begin
          if (expired(mbc, cfg_i.blink_ticks)) begin
            mbc = '0;
            blink_d[1] = ~blink_d[1];
          end
          lamps_d = {1'b0, blink_d[1], 1'b0};
          if (mphase_d == MP_PRE_RED && expired(prc, cfg_i.pre_red_ticks)) begin
            mphase_d = MP_RED;
          end
        end
        default:   lamps_d = '0;
      endcase
      prev_d[3:1] = buttons[3:1];
    end else begin
      unique case (aphase_d)
        AP_YELLOW: begin
          if (expired(abc, cfg_i.blink_ticks)) begin
            abc = '0;
            blink_d[0] = ~blink_d[0];
            lamps_d[LampYel] = blink_d[0];
          end
          if (expired(pc, cfg_i.yellow_ticks)) begin
            lamps_d[LampYel] = 1'b0;
            aphase_d = AP_RED;
            pc = '0;
          end
        end
        AP_RED: begin
          lamps_d[LampRed] = 1'b1;
          if (expired(pc, cfg_i.red_ticks)) begin
            lamps_d[LampRed] = 1'b0;
            aphase_d = AP_GREEN;
            pc = '0;
          end
        end
        default: begin
          lamps_d[LampGrn] = 1'b1;
          if (expired(pc, cfg_i.green_ticks)) begin
            lamps_d[LampGrn] = 1'b0;
            aphase_d = AP_YELLOW;
            pc = '0;
          end
        end
      endcase
    end

    phase_cnt_d = sat_inc(pc);
    ablink_cnt_d = sat_inc(abc);
    mblink_cnt_d = sat_inc(mbc);
    prered_cnt_d = sat_inc(prc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q <= 1'b0;
      prev_q <= '0;
      aphase_q <= AP_GREEN;
      mphase_q <= MP_OFF;
      phase_cnt_q <= '0;
      ablink_cnt_q <= '0;
      mblink_cnt_q <= '0;
      prered_cnt_q <= '0;
      blink_q <= '0;
      lamps_q <= '0;
    end else if (step_i) begin
      manual_q <= manual_d;
      prev_q <= prev_d;
      aphase_q <= aphase_d;
      mphase_q <= mphase_d;
      phase_cnt_q <= phase_cnt_d;
      ablink_cnt_q <= ablink_cnt_d;
      mblink_cnt_q <= mblink_cnt_d;
      prered_cnt_q <= prered_cnt_d;
      blink_q <= blink_d;
      lamps_q <= lamps_d;
    end
  end

  assign res_o.red_lamp = lamps_d[LampRed];
  assign res_o.yellow_lamp = lamps_d[LampYel];
  assign res_o.green_lamp = lamps_d[LampGrn];
  assign res_o.in_manual = manual_d;

endmodule

FILE: src/traffic_light_controller.sv
// Traffic light controller top level: configuration registers and output buffer.
// A result beat is registered into the output buffer when its tick beat is accepted.
// Throughput: one tick beat per cycle unless the two-entry output buffer is full; it
// keeps input open while one result waits. Reset clears all phase state, counters and
// lamps, and loads the configuration registers with their default durations.
// Depends on tlc_pkg and tlc_core.
module traffic_light_controller #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tlc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tlc_pkg::out_t                       out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tlc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [tlc_pkg::CfgWidth-1:0]        cfg_data_i
);

  tlc_pkg::cfg_t cfg_q;
  tlc_pkg::out_t res;
  tlc_pkg::out_t head_q, skid_q;
  logic          head_vld_q, skid_vld_q;
  logic          in_acc, out_pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = ~skid_vld_q;
  assign in_acc = in_valid_i & in_ready_o;
  assign out_pop = head_vld_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_ticks <= tlc_pkg::GreenTicksReset;
      cfg_q.yellow_ticks <= tlc_pkg::YellowTicksReset;
      cfg_q.red_ticks <= tlc_pkg::RedTicksReset;
      cfg_q.blink_ticks <= tlc_pkg::BlinkTicksReset;
      cfg_q.pre_red_ticks <= tlc_pkg::PreRedTicksReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tlc_pkg::CFG_GREEN_TICKS:   cfg_q.green_ticks <= cfg_data_i;
        tlc_pkg::CFG_YELLOW_TICKS:  cfg_q.yellow_ticks <= cfg_data_i;
        tlc_pkg::CFG_RED_TICKS:     cfg_q.red_ticks <= cfg_data_i;
        tlc_pkg::CFG_BLINK_TICKS:   cfg_q.blink_ticks <= cfg_data_i;
        tlc_pkg::CFG_PRE_RED_TICKS: cfg_q.pre_red_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tlc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_acc),
    .tick_i(in_data_i),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // Valid flags of the two-entry output buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_pop) begin
      head_vld_q <= skid_vld_q | in_acc;
      skid_vld_q <= skid_vld_q & in_acc;
    end else if (head_vld_q) begin
      skid_vld_q <= skid_vld_q | in_acc;
    end else begin
      head_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
        skid_q <= res;
      end else begin
        head_q <= res;
      end
    end else if (head_vld_q) begin
      if (in_acc) begin
        skid_q <= res;
      end
    end else if (in_acc) begin
      head_q <= res;
    end
  end

  assign out_valid_o = head_vld_q;
  assign out_data_o = head_q;

endmodule

FILE: src/tlc_checker.sv
// Port-level checks for the traffic light controller, bound to the top level.
// Depends on tlc_pkg and traffic_light_controller.
module tlc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input tlc_pkg::out_t out_data_o
);

  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.red_lamp, out_data_o.yellow_lamp,
                                out_data_o.green_lamp}) <= 1)
    else $error("More than one lamp is lit in a result beat.");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("An accepted tick beat gave no result beat.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("A stalled result beat changed or vanished.");

  a_drain_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("The result beat was dropped without being taken.");

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/tb_top.sv
// Self-checking testbench for traffic_light_controller: a lamp scoreboard predicts
// each result beat from accepted tick beats while tasks drive ticks and register writes.
// Depends on tlc_pkg and the traffic_light_controller RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned MaxShown = 20;
  localparam int unsigned CfgWidth = tlc_pkg::CfgWidth;
  localparam int unsigned CfgIndexWidth = tlc_pkg::CfgIndexWidth;

  typedef enum logic [1:0] {AUTO_GREEN, AUTO_YELLOW, AUTO_RED} auto_phase_e;
  typedef enum logic [2:0] {
    MAN_OFF, MAN_RED, MAN_YELLOW, MAN_BLINK, MAN_PRE_RED, MAN_GREEN
  } manual_phase_e;

  // Tick levels are written in field order: mode, red, yellow, green.
  localparam tlc_pkg::in_t DirectedTicks [24] = '{
    4'b0000, 4'b1111, 4'b0000, 4'b0001, 4'b0000, 4'b0001, 4'b0010, 4'b0010,
    4'b0010, 4'b0000, 4'b0010, 4'b0100, 4'b0000, 4'b0100, 4'b0000, 4'b0000,
    4'b1000, 4'b0111, 4'b0111, 4'b1111, 4'b0000, 4'b1000, 4'b0000, 4'b0000
  };

  class lamp_scoreboard;
    logic [CfgWidth-1:0] green_len, yellow_len, red_len, blink_len, pre_red_len;
    bit manual_on;
    bit [3:0] prev_levels;
    auto_phase_e auto_ph;
    manual_phase_e man_ph;
    bit [CountWidth-1:0] phase_cnt, auto_blink_cnt, man_blink_cnt, pre_red_cnt;
    bit auto_blink, man_blink, red_on, yellow_on, green_on;
    tlc_pkg::out_t expected_lamps[$];
    int tick_count, checked_count, fail_count, mode_flips;

    function new();
      green_len = tlc_pkg::GreenTicksReset;
      yellow_len = tlc_pkg::YellowTicksReset;
      red_len = tlc_pkg::RedTicksReset;
      blink_len = tlc_pkg::BlinkTicksReset;
      pre_red_len = tlc_pkg::PreRedTicksReset;
      manual_on = 1'b0;
      prev_levels = '0;
      auto_ph = AUTO_GREEN;
      man_ph = MAN_OFF;
      phase_cnt = '0;
      auto_blink_cnt = '0;
      man_blink_cnt = '0;
      pre_red_cnt = '0;
      auto_blink = 1'b0;
      man_blink = 1'b0;
      {red_on, yellow_on, green_on} = 3'b000;
      tick_count = 0;
      checked_count = 0;
      fail_count = 0;
      mode_flips = 0;
    endfunction

    function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
      case (idx)
        tlc_pkg::CFG_GREEN_TICKS: green_len = val;
        tlc_pkg::CFG_YELLOW_TICKS: yellow_len = val;
        tlc_pkg::CFG_RED_TICKS: red_len = val;
        tlc_pkg::CFG_BLINK_TICKS: blink_len = val;
        tlc_pkg::CFG_PRE_RED_TICKS: pre_red_len = val;
        default: ;
      endcase
    endfunction

    function bit [CountWidth-1:0] bump(bit [CountWidth-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void manual_tick(bit [3:0] rise);
      if (rise[2]) begin
        if (man_ph == MAN_RED) begin
          man_ph = MAN_OFF;
        end else begin
          man_ph = MAN_PRE_RED;
          man_blink_cnt = '0;
          pre_red_cnt = '0;
          man_blink = 1'b1;
        end
      end
      if (rise[1]) begin
        if (man_ph == MAN_YELLOW || man_ph == MAN_BLINK) begin
          man_ph = MAN_OFF;
        end else begin
          man_ph = MAN_BLINK;
          man_blink_cnt = '0;
          man_blink = 1'b1;
        end
      end
      if (rise[0]) man_ph = (man_ph == MAN_GREEN) ? MAN_OFF : MAN_GREEN;

      case (man_ph)
        MAN_RED: {red_on, yellow_on, green_on} = 3'b100;
        MAN_YELLOW: {red_on, yellow_on, green_on} = 3'b010;
        MAN_GREEN: {red_on, yellow_on, green_on} = 3'b001;
        MAN_BLINK, MAN_PRE_RED: begin
          if (man_blink_cnt >= blink_len) begin
            man_blink_cnt = '0;
            man_blink = !man_blink;
          end
          {red_on, yellow_on, green_on} = {1'b0, man_blink, 1'b0};
          if (man_ph == MAN_PRE_RED && pre_red_cnt >= pre_red_len) man_ph = MAN_RED;
        end
        default: {red_on, yellow_on, green_on} = 3'b000;
      endcase
    endfunction

    function void auto_tick();
      case (auto_ph)
        AUTO_YELLOW: begin
          if (auto_blink_cnt >= blink_len) begin
            auto_blink_cnt = '0;
            auto_blink = !auto_blink;
            yellow_on = auto_blink;
          end
          if (phase_cnt >= yellow_len) begin
            yellow_on = 1'b0;
            auto_ph = AUTO_RED;
            phase_cnt = '0;
          end
        end
        AUTO_RED: begin
          red_on = 1'b1;
          if (phase_cnt >= red_len) begin
            red_on = 1'b0;
            auto_ph = AUTO_GREEN;
            phase_cnt = '0;
          end
        end
        default: begin
          green_on = 1'b1;
          if (phase_cnt >= green_len) begin
            green_on = 1'b0;
            auto_ph = AUTO_YELLOW;
            phase_cnt = '0;
          end
        end
      endcase
    endfunction

    function void note_tick(tlc_pkg::in_t b);
      bit [3:0] levels;
      bit [3:0] rise;
      tlc_pkg::out_t want;
      levels = b;
      rise = levels & ~prev_levels;
      prev_levels[3] = levels[3];
      if (rise[3]) begin
        manual_on = !manual_on;
        mode_flips++;
        {red_on, yellow_on, green_on} = 3'b000;
        if (manual_on) begin
          man_ph = MAN_OFF;
        end else begin
          auto_ph = AUTO_GREEN;
          phase_cnt = '0;
        end
      end
      if (manual_on) begin
        manual_tick(rise);
        prev_levels[2:0] = levels[2:0];
      end else begin
        auto_tick();
      end
      phase_cnt = bump(phase_cnt);
      auto_blink_cnt = bump(auto_blink_cnt);
      man_blink_cnt = bump(man_blink_cnt);
      pre_red_cnt = bump(pre_red_cnt);
      want.red_lamp = red_on;
      want.yellow_lamp = yellow_on;
      want.green_lamp = green_on;
      want.in_manual = manual_on;
      expected_lamps.push_back(want);
      tick_count++;
    endfunction

    task report(string msg);
      if (fail_count < MaxShown) $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want) begin
        report($sformatf("result beat %0d %s is %b, expected %b", checked_count, name,
                         got, want));
      end
    endtask

    task check_lamps(tlc_pkg::out_t got);
      tlc_pkg::out_t want;
      if (expected_lamps.size() == 0) begin
        report($sformatf("result beat %b arrived with no tick outstanding", got));
        return;
      end
      want = expected_lamps.pop_front();
      checked_count++;
      compare_field("red_lamp", got.red_lamp, want.red_lamp);
      compare_field("yellow_lamp", got.yellow_lamp, want.yellow_lamp);
      compare_field("green_lamp", got.green_lamp, want.green_lamp);
      compare_field("in_manual", got.in_manual, want.in_manual);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tlc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tlc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0] cfg_data = '0;

  lamp_scoreboard sb = new();
  bit [3:0] held_levels = '0;
  int settings_count = 0;
  int holds_done = 0;
  int hold_marks [2] = '{400, 1200};

  traffic_light_controller #(
    .COUNT_WIDTH(CountWidth)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_tick(in_data);
    if (rst_n && out_valid && out_ready) sb.check_lamps(out_data);
  end

  // The receiver periodically picks a random stall pattern and twice holds off for a
  // long stretch so that the output buffer fills and the input stalls.
  initial begin
    int style;
    int cycle;
    style = 0;
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (holds_done < 2 && sb.tick_count >= hold_marks[holds_done]) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        if (cycle % 50 == 0) style = $urandom_range(0, 2);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic tlc_pkg::in_t next_levels();
    if ($urandom_range(0, 9) == 0) return tlc_pkg::in_t'($urandom_range(0, 15));
    if ($urandom_range(0, 29) == 0) held_levels[3] = !held_levels[3];
    for (int b = 0; b < 3; b++) begin
      if ($urandom_range(0, 4) == 0) held_levels[b] = !held_levels[b];
    end
    return tlc_pkg::in_t'(held_levels);
  endfunction

  task automatic send_tick(tlc_pkg::in_t t);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_stream(int n);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_tick(next_levels());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= tlc_pkg::in_t'($urandom_range(0, 15));
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_lamps.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic write_settings(int grn, int yel, int red, int blink, int pre_red,
                                bit touch_spare);
    cfg_beat(tlc_pkg::CFG_GREEN_TICKS, CfgWidth'(grn));
    cfg_beat(tlc_pkg::CFG_YELLOW_TICKS, CfgWidth'(yel));
    cfg_beat(tlc_pkg::CFG_RED_TICKS, CfgWidth'(red));
    cfg_beat(tlc_pkg::CFG_BLINK_TICKS, CfgWidth'(blink));
    cfg_beat(tlc_pkg::CFG_PRE_RED_TICKS, CfgWidth'(pre_red));
    if (touch_spare) begin
      cfg_beat(CfgIndexWidth'(tlc_pkg::CFG_PRE_RED_TICKS + $urandom_range(1, 3)),
               CfgWidth'($urandom_range(0, 65535)));
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_count = 1;

    foreach (DirectedTicks[i]) send_tick(DirectedTicks[i]);
    in_valid <= 1'b0;
    wait_idle();

    write_settings(1, 1, 1, 1, 1, 1'b0);
    send_stream(280);
    wait_idle();

    write_settings(65535, 65535, 65535, 65535, 65535, 1'b1);
    send_stream(150);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_settings($urandom_range(1, 12), $urandom_range(1, 25), $urandom_range(1, 12),
                     $urandom_range(1, 4), $urandom_range(1, 20), 1'b0);
      send_stream(270);
      wait_idle();
    end

    write_settings(2, 30, 3, 65535, $urandom_range(1, 6), 1'b0);
    send_stream(200);
    wait_idle();
    repeat (5) @(posedge clk);

    $display("Covered %0d tick beats over %0d register settings and %0d mode changes.",
             sb.tick_count, settings_count, sb.mode_flips);
    $display("Checked %0d result beats after %0d long receiver hold-offs; %0d mismatches.",
             sb.checked_count, holds_done, sb.fail_count);
    if (sb.fail_count == 0 && sb.expected_lamps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: traffic_light_controller.f
src/tlc_pkg.sv
src/tlc_core.sv
src/traffic_light_controller.sv
src/tlc_checker.sv
tb/tb_top.sv
